[rtl/core/bbipf_pkg.sv]
// ----------------------------------------------------------------------------
// bbipf_pkg
// Shared types and constants of the band binarize / isolated pixel filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bbipf_pkg;

    // Pixel and count widths.
    localparam int PIXEL_W  = 8;
    localparam int COUNT_W  = 25;

    localparam logic [PIXEL_W-1:0] WHITE     = 8'd255;
    localparam logic [PIXEL_W-1:0] BLACK     = 8'd0;
    localparam logic [PIXEL_W-1:0] BAND_LOW  = 8'd1;
    localparam logic [PIXEL_W-1:0] BAND_HIGH = 8'd224;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h1FF_FFFF;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BINARIZE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENOISE_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // One result beat.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               frame_end;
        logic [COUNT_W-1:0] white_count;
        logic               mostly_white;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/bbipf_if.sv]
// ----------------------------------------------------------------------------
// bbipf_if
// Valid/ready channels of the filter: pixel input, result output, config.
// ----------------------------------------------------------------------------
`default_nettype none

// Pixel input channel.
interface bbipf_pixel_if
    import bbipf_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// Result output channel.
interface bbipf_result_if
    import bbipf_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               frame_end;
    logic [COUNT_W-1:0] white_count;
    logic               mostly_white;

    modport source (output valid, output pixel_out, output frame_end,
                    output white_count, output mostly_white, input ready);
    modport sink   (input valid, input pixel_out, input frame_end,
                    input white_count, input mostly_white, output ready);
endinterface

// Configuration write channel.
interface bbipf_cfg_if
    import bbipf_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/band_binarize_isolated_pixel_filter_core.sv]
// ----------------------------------------------------------------------------
// band_binarize_isolated_pixel_filter_core
// Streaming band binarization with isolated white pixel removal and a
// per-frame white pixel count.
// ----------------------------------------------------------------------------
// Usage:
// Gray pixels enter on the pixels channel in raster order, one per beat.
// Each pixel is binarized as it arrives and held until its right neighbour
// is known, so output pixels run one column behind: column 0 of a row gives
// no beat, a middle column gives one, the last column gives two. The last
// beat of the frame carries frame_end, the white count and mostly_white.
// Results go into a four-entry result queue whose head drives the results
// channel from registers. A result enters the queue as the pixel that
// completes it is accepted. Throughput is one pixel per cycle; pixels.ready
// drops only while fewer than two queue entries are free, so a stalled
// receiver stops the input within a beat and nothing is lost.
// Configuration writes on the cfg channel are taken every cycle and must be
// made while the block is idle; a new size applies to the next pixel.
// Reset clears the position, the pending pixel, the count and the queue and
// loads the registers with binarize and denoise off and a 640x480 frame.
// ----------------------------------------------------------------------------
`default_nettype none

module band_binarize_isolated_pixel_filter_core
    import bbipf_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    bbipf_pixel_if.sink       pixels,
    bbipf_result_if.source    results,
    bbipf_cfg_if.sink         cfg
);

    // Counter and dimension widths.
    localparam int CNT_W  = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int EXT_W  = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
    localparam int AREA_W = 2 * DIM_W;
    localparam int X10_W  = COUNT_W + 4;
    localparam int CMP_W  = (AREA_W > X10_W) ? AREA_W : X10_W;

    // Clamp a configured dimension to 2..MAX_DIMENSION.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [EXT_W-1:0] ve;
        logic [EXT_W-1:0] r;
        ve = EXT_W'(v);
        if (ve < EXT_W'(2))
            r = EXT_W'(2);
        else if (ve > EXT_W'(MAX_DIMENSION))
            r = EXT_W'(MAX_DIMENSION);
        else
            r = ve;
        return DIM_W'(r);
    endfunction

    // Saturating count of one more white pixel.
    function automatic logic [COUNT_W-1:0] count_white(input logic [COUNT_W-1:0] t,
                                                       input logic [PIXEL_W-1:0] p);
        logic [COUNT_W-1:0] r;
        r = t;
        if (p == WHITE && t < COUNT_MAX)
            r = t + COUNT_W'(1);
        return r;
    endfunction

    // Configuration registers.
    logic                  binarize_enable_reg;
    logic                  denoise_enable_reg;
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [AREA_W-1:0]     area;

    // Stream state.
    logic [CNT_W-1:0]   column_count_reg, column_count_next;
    logic [CNT_W-1:0]   row_count_reg, row_count_next;
    logic [PIXEL_W-1:0] pending_pixel_reg, pending_pixel_next;
    logic [PIXEL_W-1:0] left_filtered_reg, left_filtered_next;
    logic [COUNT_W-1:0] white_total_reg, white_total_next;

    // Result queue.
    result_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  fifo_count_reg;

    logic                   accept;
    logic                   pop;
    logic [1:0]             push_n;
    result_t                entry0, entry1;

    logic [DIM_W-1:0]       width_cl, height_cl;
    logic                   last_col, last_row;
    logic [PIXEL_W-1:0]     cur;
    logic [PIXEL_W-1:0]     r1, r2;
    logic [COUNT_W-1:0]     t1, t2;
    logic [CMP_W-1:0]       t2_x10;
    logic                   mostly_white;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binarize_enable_reg <= 1'b0;
            denoise_enable_reg  <= 1'b0;
            frame_width_reg     <= RESET_FRAME_WIDTH;
            frame_height_reg    <= RESET_FRAME_HEIGHT;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BINARIZE_ENABLE: binarize_enable_reg <= cfg.data[0];
                REG_DENOISE_ENABLE:  denoise_enable_reg  <= cfg.data[0];
                REG_FRAME_WIDTH:     frame_width_reg     <= cfg.data;
                REG_FRAME_HEIGHT:    frame_height_reg    <= cfg.data;
                default:             ;
            endcase
        end
    end

    // Clamped frame size and its area for the mostly-white test.
    assign width_cl  = clamp_dim(frame_width_reg);
    assign height_cl = clamp_dim(frame_height_reg);
    assign area      = AREA_W'(width_cl) * AREA_W'(height_cl);

    // Handshakes.
    assign pixels.ready = (fifo_count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign accept       = pixels.valid && pixels.ready;
    assign pop          = results.valid && results.ready;

    // Position of the incoming pixel.
    assign last_col = DIM_W'(column_count_reg) >= (width_cl - DIM_W'(1));
    assign last_row = DIM_W'(row_count_reg) >= (height_cl - DIM_W'(1));

    // Band binarization on arrival.
    always_comb
    begin
        if (!binarize_enable_reg)
            cur = pixels.pixel_in;
        else if (pixels.pixel_in >= BAND_LOW && pixels.pixel_in <= BAND_HIGH)
            cur = WHITE;
        else
            cur = BLACK;
    end

    // Pending pixel against its neighbours; column 0 and the last row pass.
    always_comb
    begin
        r1 = pending_pixel_reg;
        if (denoise_enable_reg && column_count_reg != CNT_W'(1) && !last_row &&
            pending_pixel_reg == WHITE && left_filtered_reg != WHITE && cur != WHITE)
            r1 = BLACK;
    end

    // Last column pixel; its right neighbour lies outside the row.
    always_comb
    begin
        r2 = cur;
        if (denoise_enable_reg && !last_row && cur == WHITE && r1 != WHITE)
            r2 = BLACK;
    end

    // White count and mostly-white flag.
    assign t1     = count_white(white_total_reg, r1);
    assign t2     = count_white(t1, r2);
    assign t2_x10 = CMP_W'({t2, 3'b000}) + CMP_W'({t2, 1'b0});
    assign mostly_white = t2_x10 > CMP_W'(area);

    // Result beats of this pixel.
    always_comb
    begin
        entry0.pixel_out    = r1;
        entry0.frame_end    = 1'b0;
        entry0.white_count  = '0;
        entry0.mostly_white = 1'b0;
        entry1.pixel_out    = r2;
        entry1.frame_end    = last_row;
        entry1.white_count  = last_row ? t2 : '0;
        entry1.mostly_white = last_row && mostly_white;
    end

    // Stream state update.
    always_comb
    begin
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        pending_pixel_next = pending_pixel_reg;
        left_filtered_next = left_filtered_reg;
        white_total_next   = white_total_reg;
        push_n             = 2'd0;
        if (accept)
        begin
            if (column_count_reg == '0)
            begin
                pending_pixel_next = cur;
                column_count_next  = CNT_W'(1);
            end
            else if (!last_col)
            begin
                pending_pixel_next = cur;
                column_count_next  = column_count_reg + CNT_W'(1);
                left_filtered_next = r1;
                white_total_next   = t1;
                push_n             = 2'd1;
            end
            else
            begin
                column_count_next  = '0;
                pending_pixel_next = BLACK;
                push_n             = 2'd2;
                if (last_row)
                begin
                    row_count_next     = '0;
                    white_total_next   = '0;
                    left_filtered_next = BLACK;
                end
                else
                begin
                    row_count_next     = row_count_reg + CNT_W'(1);
                    white_total_next   = t2;
                    left_filtered_next = r2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            pending_pixel_reg <= '0;
            left_filtered_reg <= '0;
            white_total_reg   <= '0;
        end
        else
        begin
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            pending_pixel_reg <= pending_pixel_next;
            left_filtered_reg <= left_filtered_next;
            white_total_reg   <= white_total_next;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= entry0;
        if (push_n == 2'd2)
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= entry1;
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg + FIFO_PTR_W'(push_n);
            rd_ptr_reg     <= rd_ptr_reg + FIFO_PTR_W'(pop);
            fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
        end
    end

    // Queue head drives the output channel.
    assign results.valid        = (fifo_count_reg != '0);
    assign results.pixel_out    = fifo_reg[rd_ptr_reg].pixel_out;
    assign results.frame_end    = fifo_reg[rd_ptr_reg].frame_end;
    assign results.white_count  = fifo_reg[rd_ptr_reg].white_count;
    assign results.mostly_white = fifo_reg[rd_ptr_reg].mostly_white;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // A pixel at column 0 only opens the row and moves to column 1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && column_count_reg == '0) |=>
            (column_count_reg == CNT_W'(1) && $stable(fifo_count_reg) == !$past(pop)))
        else $error("column 0 pixel mishandled");

    // Count and flag appear only on the frame's last beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.frame_end) |->
            (results.white_count == '0 && !results.mostly_white))
        else $error("frame summary outside frame end");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the band binarize / isolated pixel filter core.
// Gray pixels stream in through a valid/ready driver with random gaps, and a
// clocked monitor checks every result beat against an in-bench model of the
// filter. The run covers the reset frame size, two short directed pixel
// sequences, then random frames over a range of sizes and enable settings.
// Frame sizes and enables are reprogrammed between phases, sometimes in the
// middle of a frame. Dimensions below, at and above the legal range are
// included. Once during the run the result side holds off long enough to
// fill the core's queue and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bbipf_pkg::*;

    localparam int MAX_DIM = 4096;
    localparam int RANDOM_PHASES = 14;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side copies of everything the core reads, known from time zero.
    logic                  pix_valid = 1'b0;
    logic [PIXEL_W-1:0]    pix_data = '0;
    logic                  res_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bbipf_pixel_if  pix_if ();
    bbipf_result_if res_if ();
    bbipf_cfg_if    cfg_if ();

    assign pix_if.valid    = pix_valid;
    assign pix_if.pixel_in = pix_data;
    assign res_if.ready    = res_ready;
    assign cfg_if.valid    = cfg_valid;
    assign cfg_if.index    = cfg_index;
    assign cfg_if.data     = cfg_data;

    band_binarize_isolated_pixel_filter_core #(
        .MAX_DIMENSION (MAX_DIM)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    // Pixels waiting to be driven and result beats waiting to be seen.
    logic [PIXEL_W-1:0] pixel_stream[$];
    result_t            expected_beats[$];

    int unsigned pixels_accepted = 0;
    int unsigned mismatches = 0;
    logic        pix_taken = 1'b0;
    logic        hold_off = 1'b0;
    logic        src_idle_en = 1'b1;
    logic        snk_idle_en = 1'b1;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;

    // Filter model: register copies and stream state, all at reset values.
    logic                  bin_on = 1'b0;
    logic                  denoise_on = 1'b0;
    logic [CFG_DATA_W-1:0] width_reg = RESET_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] height_reg = RESET_FRAME_HEIGHT;
    logic [11:0]           col_pos = '0;
    logic [11:0]           row_pos = '0;
    logic [PIXEL_W-1:0]    held_pixel = '0;
    logic [PIXEL_W-1:0]    left_pixel = '0;
    logic [COUNT_W-1:0]    white_total = '0;

    always #5 clk = ~clk;

    // Dimensions outside 2..MAX_DIM are used clamped.
    function automatic logic [CFG_DATA_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        if (v < 2)
            return CFG_DATA_W'(2);
        if (v > MAX_DIM)
            return CFG_DATA_W'(MAX_DIM);
        return v;
    endfunction

    // Finish one pixel: apply denoise, update the count and queue its beat.
    function automatic void filter_pixel(input logic [PIXEL_W-1:0] pix,
                                         input logic [PIXEL_W-1:0] right,
                                         input logic [11:0] col,
                                         input logic last_row,
                                         input logic fend,
                                         input logic [CFG_DATA_W-1:0] w,
                                         input logic [CFG_DATA_W-1:0] h);
        result_t beat;
        logic [PIXEL_W-1:0] res;
        res = pix;
        if (denoise_on && col != 0 && !last_row && pix == WHITE &&
            left_pixel != WHITE && right != WHITE)
            res = BLACK;
        left_pixel = res;
        if (res == WHITE && white_total != COUNT_MAX)
            white_total = white_total + 1'b1;
        beat.pixel_out    = res;
        beat.frame_end    = fend;
        beat.white_count  = fend ? white_total : '0;
        beat.mostly_white = fend &&
            (64'(white_total) * 64'd10 > 64'(w) * 64'(h));
        expected_beats = {expected_beats, beat};
    endfunction

    // Advance the model by one accepted pixel.
    function automatic void predict_pixel(input logic [PIXEL_W-1:0] raw);
        logic [CFG_DATA_W-1:0] w_eff;
        logic [CFG_DATA_W-1:0] h_eff;
        logic [PIXEL_W-1:0]    cur;
        logic                  last_col;
        logic                  last_row;
        w_eff = clamp_dim(width_reg);
        h_eff = clamp_dim(height_reg);
        cur = raw;
        if (bin_on)
            cur = (raw >= BAND_LOW && raw <= BAND_HIGH) ? WHITE : BLACK;
        last_col = {1'b0, col_pos} >= w_eff - 1'b1;
        last_row = {1'b0, row_pos} >= h_eff - 1'b1;

        // Column 0 only waits for its right neighbor.
        if (col_pos == 0) begin
            held_pixel = cur;
            col_pos = 12'd1;
            return;
        end

        filter_pixel(held_pixel, cur, col_pos - 1'b1, last_row, 1'b0, w_eff, h_eff);
        if (!last_col) begin
            held_pixel = cur;
            col_pos = col_pos + 1'b1;
            return;
        end

        // Last column: the pixel itself follows, with black on its right.
        filter_pixel(cur, BLACK, col_pos, last_row, last_row, w_eff, h_eff);
        col_pos = '0;
        held_pixel = '0;
        if (last_row) begin
            row_pos = '0;
            white_total = '0;
            left_pixel = '0;
        end
        else begin
            row_pos = row_pos + 1'b1;
        end
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random gray value, biased toward values that end up white.
    function automatic logic [PIXEL_W-1:0] gen_pixel(input logic bin,
                                                     input int unsigned white_pct);
        if ($urandom_range(0, 99) < 10)
            return PIXEL_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < white_pct) begin
            if (!bin)
                return WHITE;
            case ($urandom_range(0, 3))
                0: return BAND_LOW;
                1: return BAND_HIGH;
                default: return PIXEL_W'($urandom_range(1, 224));
            endcase
        end
        if (!bin)
            return PIXEL_W'($urandom_range(0, 254));
        case ($urandom_range(0, 3))
            0: return BLACK;
            1: return BAND_HIGH + 1'b1;
            2: return WHITE;
            default: return PIXEL_W'($urandom_range(225, 255));
        endcase
    endfunction

    // One register write; returns once the beat is taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // Sizes go first, then the two enables.
    task automatic configure(input logic b_en, input logic d_en,
                             input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_BINARIZE_ENABLE, CFG_DATA_W'(b_en));
        write_reg(REG_DENOISE_ENABLE, CFG_DATA_W'(d_en));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every pixel is in and every beat is out, then let it settle.
    task automatic drain_and_settle();
        while (pixel_stream.size() != 0 || pix_valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Pixel driver: hold a beat until taken, then maybe idle, then send the next.
    always @(negedge clk) begin
        if (rst_n && (!pix_valid || pix_taken)) begin
            if (src_gap != 0) begin
                pix_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (pixel_stream.size() != 0) begin
                pix_valid <= 1'b1;
                pix_data <= pixel_stream.pop_front();
                src_gap <= src_idle_en ? pick_gap() : 0;
            end
            else begin
                pix_valid <= 1'b0;
            end
        end
    end

    // Result-side ready with random stalls and the long hold-off.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_off) begin
                res_ready <= 1'b0;
            end
            else if (snk_gap != 0) begin
                res_ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end
            else begin
                res_ready <= 1'b1;
                snk_gap <= snk_idle_en ? pick_gap() : 0;
            end
        end
    end

    // Monitor: check result beats, feed the model with accepted pixels and
    // register writes.
    always @(posedge clk) begin
        result_t got;
        result_t exp;
        if (rst_n) begin
            if (res_if.valid && res_ready) begin
                got.pixel_out    = res_if.pixel_out;
                got.frame_end    = res_if.frame_end;
                got.white_count  = res_if.white_count;
                got.mostly_white = res_if.mostly_white;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected beat: pixel %0d end %0b count %0d mostly %0b",
                                 $realtime, got.pixel_out, got.frame_end,
                                 got.white_count, got.mostly_white);
                end
                else begin
                    exp = expected_beats.pop_front();
                    if (got.pixel_out !== exp.pixel_out ||
                        got.frame_end !== exp.frame_end ||
                        got.white_count !== exp.white_count ||
                        got.mostly_white !== exp.mostly_white) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: exp pixel %0d end %0b count %0d mostly %0b, got pixel %0d end %0b count %0d mostly %0b",
                                     $realtime, exp.pixel_out, exp.frame_end,
                                     exp.white_count, exp.mostly_white,
                                     got.pixel_out, got.frame_end,
                                     got.white_count, got.mostly_white);
                    end
                end
            end
            if (pix_valid && pix_if.ready) begin
                predict_pixel(pix_data);
                pixels_accepted++;
            end
            if (cfg_valid && cfg_if.ready) begin
                case (cfg_index)
                    REG_BINARIZE_ENABLE: bin_on = cfg_data[0];
                    REG_DENOISE_ENABLE:  denoise_on = cfg_data[0];
                    REG_FRAME_WIDTH:     width_reg = cfg_data;
                    REG_FRAME_HEIGHT:    height_reg = cfg_data;
                    default: ;
                endcase
            end
        end
        pix_taken <= rst_n && pix_valid && pix_if.ready;
    end

    // Long receiver hold-off while the sender still has plenty to offer.
    initial begin : backpressure
        while (!(pixels_accepted >= 150 && pixel_stream.size() >= 10))
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (64) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin : timeout
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int unsigned           n_items;
        int unsigned           white_pct;
        logic                  b_en;
        logic                  d_en;
        logic [CFG_DATA_W-1:0] w_sel;
        logic [CFG_DATA_W-1:0] h_sel;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: 640x480, both enables off.
        pixel_stream = '{8'd255, 8'd0, 8'd128};
        drain_and_settle();

        // Narrow frame entered mid-row: band edges, isolated whites, last row.
        configure(1'b1, 1'b1, 13'd4, 13'd3);
        pixel_stream = '{8'd1,
                         8'd0, 8'd200, 8'd0, 8'd0,
                         8'd224, 8'd0, 8'd225, 8'd1,
                         8'd255, 8'd224, 8'd0, 8'd1,
                         8'd1, 8'd1, 8'd0, 8'd128};
        drain_and_settle();

        // Dimensions below range, denoise on raw 255 values.
        configure(1'b0, 1'b1, 13'd0, 13'd1);
        pixel_stream = '{8'd255, 8'd255, 8'd0, 8'd255,
                         8'd255, 8'd0, 8'd7, 8'd200};

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_and_settle();
            b_en = ($urandom_range(0, 3) != 0);
            d_en = ($urandom_range(0, 3) != 0);
            w_sel = ($urandom_range(0, 4) != 0) ? CFG_DATA_W'($urandom_range(2, 10))
                                                : CFG_DATA_W'($urandom_range(0, 8191));
            h_sel = ($urandom_range(0, 4) != 0) ? CFG_DATA_W'($urandom_range(2, 5))
                                                : CFG_DATA_W'($urandom_range(0, 8191));
            // Make sure each extreme shows up at least once.
            case (phase)
                2: w_sel = CFG_DATA_W'(MAX_DIM);
                4: w_sel = '1;
                6: h_sel = '1;
                8: h_sel = CFG_DATA_W'(MAX_DIM);
                10: begin
                    w_sel = 13'd1;
                    h_sel = 13'd0;
                end
                11: begin
                    w_sel = 13'd2;
                    h_sel = 13'd2;
                end
                default: ;
            endcase
            configure(b_en, d_en, w_sel, h_sel);
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            n_items = $urandom_range(30, 60);
            white_pct = $urandom_range(20, 80);
            for (int i = 0; i < n_items; i++)
                pixel_stream = {pixel_stream, gen_pixel(b_en, white_pct)};
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
